[rtl/cau_pkg.sv]
// Package for the complex arithmetic unit: word widths, opcodes, status codes,
// pipeline stage records and the saturation helpers.
// Depends on nothing; used by complex_arithmetic_unit.
`default_nettype none

package cau_pkg;

   localparam int WORD_BITS  = 32;
   localparam int FRAC_BITS  = 16;
   localparam int PROD_BITS  = 2 * WORD_BITS;
   localparam int WIDE_BITS  = PROD_BITS + 2;
   localparam int DIV_STEPS  = WORD_BITS + 1;
   localparam int SQRT_STEPS = WORD_BITS;
   localparam int PIPE_STEPS = DIV_STEPS;
   localparam int SPLIT_BITS = DIV_STEPS - FRAC_BITS;
   localparam int CMD_BITS   = 4;
   localparam int STAT_BITS  = 2;
   localparam int REQ_BITS   = 5 * WORD_BITS;
   localparam int RSP_RAW    = 2 * WORD_BITS + 1 + STAT_BITS;
   localparam int RSP_BITS   = ((RSP_RAW + 7) / 8) * 8;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [PROD_BITS-1:0] prod_type;
   typedef logic signed [WIDE_BITS-1:0] wide_type;
   typedef logic [PROD_BITS-1:0]        umag_type;
   typedef logic [DIV_STEPS-1:0]        quot_type;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_ADD   = 4'd0,
      CMD_SUB   = 4'd1,
      CMD_MUL   = 4'd2,
      CMD_SCALE = 4'd3,
      CMD_DIV   = 4'd4,
      CMD_NEG   = 4'd5,
      CMD_MAG   = 4'd6,
      CMD_EQ    = 4'd7,
      CMD_NE    = 4'd8,
      CMD_LESS  = 4'd9
   } cmd_type;

   typedef enum logic [STAT_BITS-1:0] {
      STAT_OK  = 2'd0,
      STAT_DZ  = 2'd1,
      STAT_SAT = 2'd2
   } stat_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam quot_type Q_POS_LIM = {2'b00, {(WORD_BITS-1){1'b1}}};
   localparam quot_type Q_NEG_LIM = {2'b01, {(WORD_BITS-1){1'b0}}};

   typedef struct packed {
      word_type val;
      logic     sat;
   } sat_type;

   typedef struct packed {
      logic                valid;
      logic [CMD_BITS-1:0] cmd;
      word_type            ar;
      word_type            ai;
      word_type            br;
      word_type            bi;
      word_type            sf;
   } in_type;

   typedef struct packed {
      logic                valid;
      logic [CMD_BITS-1:0] cmd;
      word_type            rr;
      word_type            ri;
      logic                sat;
      logic                eq;
      prod_type            arbr;
      prod_type            aibi;
      prod_type            arbi;
      prod_type            aibr;
      prod_type            arar;
      prod_type            aiai;
      prod_type            brbr;
      prod_type            bibi;
      prod_type            arsf;
      prod_type            aisf;
   } prod_stage_type;

   typedef struct packed {
      logic                valid;
      logic [CMD_BITS-1:0] cmd;
      word_type            rr;
      word_type            ri;
      logic                sat;
      logic                flag;
      umag_type            den;
      umag_type            mag_sq;
      wide_type            nr;
      wide_type            ni;
   } sum_stage_type;

   typedef struct packed {
      logic                valid;
      logic [CMD_BITS-1:0] cmd;
      word_type            rr;
      word_type            ri;
      logic                sat;
      logic                flag;
      logic                dz;
      logic                neg_re;
      logic                neg_im;
      logic                ovf_re;
      logic                ovf_im;
      umag_type            den;
      umag_type            rem_re;
      umag_type            rem_im;
      quot_type            dvd_re;
      quot_type            dvd_im;
      quot_type            q_re;
      quot_type            q_im;
      umag_type            mag_sq;
      logic [WORD_BITS+1:0] sq_rem;
      logic [WORD_BITS-1:0] sq_root;
   } step_type;

   function automatic wide_type sx(input prod_type v);
      sx = wide_type'(v);
   endfunction

   function automatic sat_type saturate(input wide_type v);
      sat_type r;
      if (v > wide_type'(WORD_MAX)) begin
         r.val = WORD_MAX;
         r.sat = 1'b1;
      end else if (v < wide_type'(WORD_MIN)) begin
         r.val = WORD_MIN;
         r.sat = 1'b1;
      end else begin
         r.val = v[WORD_BITS-1:0];
         r.sat = 1'b0;
      end
      return r;
   endfunction

   function automatic sat_type div_part(input logic neg, input logic ovf, input quot_type q);
      sat_type r;
      if (!neg) begin
         if (ovf || q > Q_POS_LIM) begin
            r.val = WORD_MAX;
            r.sat = 1'b1;
         end else begin
            r.val = q[WORD_BITS-1:0];
            r.sat = 1'b0;
         end
      end else begin
         if (ovf || q > Q_NEG_LIM) begin
            r.val = WORD_MIN;
            r.sat = 1'b1;
         end else begin
            r.val = ~q[WORD_BITS-1:0] + 1'b1;
            r.sat = 1'b0;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/complex_arithmetic_unit.sv]
// Complex arithmetic unit top level: pipelined Q16.16 complex ALU with
// bit-per-stage divider and square root. Depends on cau_pkg.
//
// Use: drive one operation per req transfer: req_tuser carries the opcode,
// req_tdata the operands a_re, a_im, b_re, b_im and scale_factor. Each
// request yields exactly one rsp transfer in order, carrying res_re,
// res_im, flag and status.
// Path: each request passes the input register, the product stage, the sum
// stage, the setup stage, the 33 restoring divider stages (one quotient bit
// each, which also carry the 32 square root stages) and the output register
// on its way to rsp_tvalid.
// Throughput: one item per cycle for every opcode while no stall holds the pipeline.
// Reset: clears all valid bits; the pipeline then is empty and
// req_tready is high.
// Stall: when rsp_tvalid is high and rsp_tready low, the whole pipeline
// holds and req_tready drops; nothing is lost or repeated. An empty
// output register lets the pipeline advance regardless of rsp_tready.
`default_nettype none

module complex_arithmetic_unit (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_tvalid,
   output logic                            req_tready,
   // a_re, a_im, b_re, b_im, scale_factor
   input  wire  [cau_pkg::REQ_BITS-1:0]    req_tdata,
   // cmd
   input  wire  [cau_pkg::CMD_BITS-1:0]    req_tuser,
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   // res_re, res_im, flag, status, zero fill
   output logic [cau_pkg::RSP_BITS-1:0]    rsp_tdata
);
   import cau_pkg::*;

   logic           adv;
   in_type         in_ff, in_in;
   prod_stage_type pr_ff, pr_in;
   sum_stage_type  sm_ff, sm_in;
   step_type       st_ff [PIPE_STEPS+1];
   step_type       st_in [PIPE_STEPS+1];
   logic           rsp_tvalid_ff;
   word_type       rr_ff, rr_in, ri_ff, ri_in;
   logic           flag_ff, flag_in;
   stat_type       stat_ff, stat_in;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_BITS-RSP_RAW){1'b0}}, stat_ff, flag_ff, ri_ff, rr_ff};

   // capture
   always_comb begin
      in_in.valid = req_tvalid;
      in_in.cmd   = req_tuser;
      in_in.ar    = req_tdata[0*WORD_BITS +: WORD_BITS];
      in_in.ai    = req_tdata[1*WORD_BITS +: WORD_BITS];
      in_in.br    = req_tdata[2*WORD_BITS +: WORD_BITS];
      in_in.bi    = req_tdata[3*WORD_BITS +: WORD_BITS];
      in_in.sf    = req_tdata[4*WORD_BITS +: WORD_BITS];
   end

   // products and direct results
   always_comb begin
      sat_type s_re, s_im;
      s_re = '0;
      s_im = '0;
      case (in_ff.cmd)
         CMD_ADD: begin
            s_re = saturate(wide_type'(in_ff.ar) + wide_type'(in_ff.br));
            s_im = saturate(wide_type'(in_ff.ai) + wide_type'(in_ff.bi));
         end
         CMD_SUB: begin
            s_re = saturate(wide_type'(in_ff.ar) - wide_type'(in_ff.br));
            s_im = saturate(wide_type'(in_ff.ai) - wide_type'(in_ff.bi));
         end
         CMD_NEG: begin
            s_re = saturate(-wide_type'(in_ff.ar));
            s_im = saturate(-wide_type'(in_ff.ai));
         end
         default: begin
            s_re = '0;
            s_im = '0;
         end
      endcase
      pr_in.valid = in_ff.valid;
      pr_in.cmd   = in_ff.cmd;
      pr_in.rr    = s_re.val;
      pr_in.ri    = s_im.val;
      pr_in.sat   = s_re.sat | s_im.sat;
      pr_in.eq    = (in_ff.ar == in_ff.br) && (in_ff.ai == in_ff.bi);
      pr_in.arbr  = in_ff.ar * in_ff.br;
      pr_in.aibi  = in_ff.ai * in_ff.bi;
      pr_in.arbi  = in_ff.ar * in_ff.bi;
      pr_in.aibr  = in_ff.ai * in_ff.br;
      pr_in.arar  = in_ff.ar * in_ff.ar;
      pr_in.aiai  = in_ff.ai * in_ff.ai;
      pr_in.brbr  = in_ff.br * in_ff.br;
      pr_in.bibi  = in_ff.bi * in_ff.bi;
      pr_in.arsf  = in_ff.ar * in_ff.sf;
      pr_in.aisf  = in_ff.ai * in_ff.sf;
   end

   // sums of products
   always_comb begin
      sat_type  s_re, s_im;
      umag_type msq;
      umag_type den;
      msq = umag_type'(pr_ff.arar) + umag_type'(pr_ff.aiai);
      den = umag_type'(pr_ff.brbr) + umag_type'(pr_ff.bibi);
      s_re = '0;
      s_im = '0;
      sm_in.flag = 1'b0;
      case (pr_ff.cmd)
         CMD_ADD, CMD_SUB, CMD_NEG: begin
            s_re.val = pr_ff.rr;
            s_im.val = pr_ff.ri;
            s_re.sat = pr_ff.sat;
         end
         CMD_MUL: begin
            s_re = saturate((sx(pr_ff.arbr) - sx(pr_ff.aibi)) >>> FRAC_BITS);
            s_im = saturate((sx(pr_ff.arbi) + sx(pr_ff.aibr)) >>> FRAC_BITS);
         end
         CMD_SCALE: begin
            s_re = saturate(sx(pr_ff.arsf) >>> FRAC_BITS);
            s_im = saturate(sx(pr_ff.aisf) >>> FRAC_BITS);
         end
         CMD_EQ:   sm_in.flag = pr_ff.eq;
         CMD_NE:   sm_in.flag = !pr_ff.eq;
         CMD_LESS: sm_in.flag = msq < den;
         default: begin
            s_re = '0;
            s_im = '0;
         end
      endcase
      sm_in.valid  = pr_ff.valid;
      sm_in.cmd    = pr_ff.cmd;
      sm_in.rr     = s_re.val;
      sm_in.ri     = s_im.val;
      sm_in.sat    = s_re.sat | s_im.sat;
      sm_in.den    = den;
      sm_in.mag_sq = msq;
      sm_in.nr     = sx(pr_ff.arbr) + sx(pr_ff.aibi);
      sm_in.ni     = sx(pr_ff.aibr) - sx(pr_ff.arbi);
   end

   // divider and square root setup
   always_comb begin
      wide_type ar_abs, ai_abs;
      ar_abs = sm_ff.nr[WIDE_BITS-1] ? -sm_ff.nr : sm_ff.nr;
      ai_abs = sm_ff.ni[WIDE_BITS-1] ? -sm_ff.ni : sm_ff.ni;
      st_in[0].valid   = sm_ff.valid;
      st_in[0].cmd     = sm_ff.cmd;
      st_in[0].rr      = sm_ff.rr;
      st_in[0].ri      = sm_ff.ri;
      st_in[0].sat     = sm_ff.sat;
      st_in[0].flag    = sm_ff.flag;
      st_in[0].dz      = sm_ff.den == '0;
      st_in[0].neg_re  = sm_ff.nr[WIDE_BITS-1];
      st_in[0].neg_im  = sm_ff.ni[WIDE_BITS-1];
      st_in[0].den     = sm_ff.den;
      st_in[0].rem_re  = ar_abs[PROD_BITS-1:0] >> SPLIT_BITS;
      st_in[0].rem_im  = ai_abs[PROD_BITS-1:0] >> SPLIT_BITS;
      st_in[0].ovf_re  = (ar_abs[PROD_BITS-1:0] >> SPLIT_BITS) >= sm_ff.den;
      st_in[0].ovf_im  = (ai_abs[PROD_BITS-1:0] >> SPLIT_BITS) >= sm_ff.den;
      st_in[0].dvd_re  = {ar_abs[SPLIT_BITS-1:0], {FRAC_BITS{1'b0}}};
      st_in[0].dvd_im  = {ai_abs[SPLIT_BITS-1:0], {FRAC_BITS{1'b0}}};
      st_in[0].q_re    = '0;
      st_in[0].q_im    = '0;
      st_in[0].mag_sq  = sm_ff.mag_sq;
      st_in[0].sq_rem  = '0;
      st_in[0].sq_root = '0;
   end

   // one quotient bit per stage, and one root bit in each of the first SQRT_STEPS stages
   for (genvar i = 0; i < PIPE_STEPS; i++) begin : g_step
      always_comb begin
         logic [PROD_BITS:0]   trial_re, trial_im;
         logic [WORD_BITS+3:0] sq_trial;
         logic [WORD_BITS+3:0] sq_sub;
         st_in[i+1] = st_ff[i];
         trial_re = {st_ff[i].rem_re, st_ff[i].dvd_re[DIV_STEPS-1]};
         trial_im = {st_ff[i].rem_im, st_ff[i].dvd_im[DIV_STEPS-1]};
         st_in[i+1].dvd_re = st_ff[i].dvd_re << 1;
         st_in[i+1].dvd_im = st_ff[i].dvd_im << 1;
         if (trial_re >= {1'b0, st_ff[i].den}) begin
            st_in[i+1].rem_re = PROD_BITS'(trial_re - {1'b0, st_ff[i].den});
            st_in[i+1].q_re   = {st_ff[i].q_re[DIV_STEPS-2:0], 1'b1};
         end else begin
            st_in[i+1].rem_re = trial_re[PROD_BITS-1:0];
            st_in[i+1].q_re   = {st_ff[i].q_re[DIV_STEPS-2:0], 1'b0};
         end
         if (trial_im >= {1'b0, st_ff[i].den}) begin
            st_in[i+1].rem_im = PROD_BITS'(trial_im - {1'b0, st_ff[i].den});
            st_in[i+1].q_im   = {st_ff[i].q_im[DIV_STEPS-2:0], 1'b1};
         end else begin
            st_in[i+1].rem_im = trial_im[PROD_BITS-1:0];
            st_in[i+1].q_im   = {st_ff[i].q_im[DIV_STEPS-2:0], 1'b0};
         end
         sq_trial = {st_ff[i].sq_rem, st_ff[i].mag_sq[PROD_BITS-1 -: 2]};
         sq_sub   = {2'b00, st_ff[i].sq_root, 2'b01};
         if (i < SQRT_STEPS) begin
            st_in[i+1].mag_sq = st_ff[i].mag_sq << 2;
            if (sq_trial >= sq_sub) begin
               st_in[i+1].sq_rem  = (WORD_BITS+2)'(sq_trial - sq_sub);
               st_in[i+1].sq_root = {st_ff[i].sq_root[WORD_BITS-2:0], 1'b1};
            end else begin
               st_in[i+1].sq_rem  = sq_trial[WORD_BITS+1:0];
               st_in[i+1].sq_root = {st_ff[i].sq_root[WORD_BITS-2:0], 1'b0};
            end
         end
      end
   end

   // final select
   always_comb begin
      sat_type s_re, s_im;
      step_type f;
      f = st_ff[PIPE_STEPS];
      s_re = div_part(f.neg_re, f.ovf_re, f.q_re);
      s_im = div_part(f.neg_im, f.ovf_im, f.q_im);
      rr_in   = f.rr;
      ri_in   = f.ri;
      flag_in = f.flag;
      stat_in = f.sat ? STAT_SAT : STAT_OK;
      case (f.cmd)
         CMD_DIV: begin
            if (f.dz) begin
               rr_in   = '0;
               ri_in   = '0;
               stat_in = STAT_DZ;
            end else begin
               rr_in   = s_re.val;
               ri_in   = s_im.val;
               stat_in = (s_re.sat | s_im.sat) ? STAT_SAT : STAT_OK;
            end
         end
         CMD_MAG: begin
            ri_in = '0;
            if (f.sq_root[WORD_BITS-1]) begin
               rr_in   = WORD_MAX;
               stat_in = STAT_SAT;
            end else begin
               rr_in   = f.sq_root;
               stat_in = STAT_OK;
            end
         end
         default: begin
            rr_in = f.rr;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff.valid   <= 1'b0;
         pr_ff.valid   <= 1'b0;
         sm_ff.valid   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         in_ff         <= in_in;
         pr_ff         <= pr_in;
         sm_ff         <= sm_in;
         rsp_tvalid_ff <= st_ff[PIPE_STEPS].valid;
         rr_ff         <= rr_in;
         ri_ff         <= ri_in;
         flag_ff       <= flag_in;
         stat_ff       <= stat_in;
      end
   end

   for (genvar j = 0; j <= PIPE_STEPS; j++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[j].valid <= 1'b0;
         end else if (adv) begin
            st_ff[j] <= st_in[j];
         end
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid_ff)
      else $error("result valid after reset");
   a_stall_only: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid_ff && !rsp_tready))
      else $error("input held off without an output stall");
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && stat_ff == STAT_DZ) |-> (rr_ff == '0 && ri_ff == '0 && !flag_ff))
      else $error("division by zero result not cleared");
   a_flag_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && flag_ff) |-> (stat_ff == STAT_OK && rr_ff == '0 && ri_ff == '0))
      else $error("comparison result carries data");

endmodule

`default_nettype wire

[tb/tb.sv]
// Testbench for complex_arithmetic_unit: random and directed complex ALU
// operations checked against an in-bench predictor of exact fixed-point results.
// Depends on cau_pkg and the complex_arithmetic_unit RTL.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cau_pkg::*;

   typedef struct {
      logic [CMD_BITS-1:0] cmd;
      logic [31:0] ar, ai, br, bi, sf;
   } op_type;

   typedef struct {
      logic [31:0] re, im;
      logic        flag;
      logic [1:0]  status;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_BITS-1:0] req_tdata = '0;
   logic [CMD_BITS-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;

   op_type     pending_ops[$];
   answer_type expected_answers[$];
   int      send_idle_pct = 17;
   int      recv_idle_pct = 65;
   int      hold_off = 0;
   bit      wait_drain = 1'b0;
   bit      stim_done = 1'b0;
   bit      req_accepted = 1'b0;
   int      error_count = 0;
   int      quiet_cycles = 0;

   complex_arithmetic_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] clamp(input logic signed [127:0] v, inout bit s);
      if (v > 128'sd2147483647) begin
         s = 1'b1;
         return 32'h7fffffff;
      end
      if (v < -128'sd2147483648) begin
         s = 1'b1;
         return 32'h80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic [63:0] root_floor(input logic [127:0] n);
      logic [127:0] r, b;
      r = 0;
      b = 128'd1 << 126;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r[63:0];
   endfunction

   function automatic answer_type alu_result(input op_type op);
      logic signed [127:0] ar, ai, br, bi, sf, d, nr, ni, qr, qi;
      answer_type a;
      bit s;
      ar = signed'(op.ar); ai = signed'(op.ai);
      br = signed'(op.br); bi = signed'(op.bi); sf = signed'(op.sf);
      a = '{0, 0, 0, STAT_OK};
      s = 1'b0;
      case (op.cmd)
         CMD_ADD: begin
            a.re = clamp(ar + br, s); a.im = clamp(ai + bi, s);
         end
         CMD_SUB: begin
            a.re = clamp(ar - br, s); a.im = clamp(ai - bi, s);
         end
         CMD_MUL: begin
            a.re = clamp((ar * br - ai * bi) >>> FRAC_BITS, s);
            a.im = clamp((ar * bi + ai * br) >>> FRAC_BITS, s);
         end
         CMD_SCALE: begin
            a.re = clamp((ar * sf) >>> FRAC_BITS, s);
            a.im = clamp((ai * sf) >>> FRAC_BITS, s);
         end
         CMD_DIV: begin
            d = br * br + bi * bi;
            if (d == 0) begin
               a.status = STAT_DZ;
            end else begin
               nr = (ar * br + ai * bi) * 65536;
               ni = (ai * br - ar * bi) * 65536;
               qr = nr / d;
               qi = ni / d;
               a.re = clamp(qr, s); a.im = clamp(qi, s);
            end
         end
         CMD_NEG: begin
            a.re = clamp(-ar, s); a.im = clamp(-ai, s);
         end
         CMD_MAG: a.re = clamp(signed'({64'd0, root_floor(ar * ar + ai * ai)}), s);
         CMD_EQ:  a.flag = (op.ar == op.br) && (op.ai == op.bi);
         CMD_NE:  a.flag = !((op.ar == op.br) && (op.ai == op.bi));
         CMD_LESS: a.flag = (ar * ar + ai * ai) < (br * br + bi * bi);
         default: ;
      endcase
      if (a.status == STAT_OK && s) a.status = STAT_SAT;
      return a;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'd0;
         3: return $urandom_range(0, 3) << 16;
         4, 5: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
         default: return $urandom();
      endcase
   endfunction

   function automatic op_type rand_op();
      op_type op;
      op.cmd = ($urandom_range(0, 49) == 0) ? CMD_BITS'($urandom_range(10, 15))
                                            : CMD_BITS'($urandom_range(0, 9));
      op.ar = rand_word(); op.ai = rand_word();
      op.br = rand_word(); op.bi = rand_word(); op.sf = rand_word();
      if ($urandom_range(0, 7) == 0) begin
         op.br = op.ar; op.bi = op.ai;
      end
      if (op.cmd == CMD_DIV && $urandom_range(0, 9) == 0) begin
         op.br = 0; op.bi = 0;
      end
      return op;
   endfunction

   task automatic add_op(input logic [CMD_BITS-1:0] c, input logic [31:0] ar, ai, br, bi, sf);
      op_type op;
      op = '{c, ar, ai, br, bi, sf};
      pending_ops.push_back(op);
   endtask

   task automatic drain();
      wait (pending_ops.size() == 0 && !req_tvalid);
      wait (expected_answers.size() == 0);
   endtask

   // record each request transfer at the edge that accepts it
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         expected_answers.push_back(alu_result('{req_tuser, req_tdata[31:0],
            req_tdata[63:32], req_tdata[95:64], req_tdata[127:96], req_tdata[159:128]}));
      end
      req_accepted <= !reset && req_tvalid && req_tready;
   end

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_accepted) begin
            if (pending_ops.size() != 0 && !wait_drain &&
                $urandom_range(0, 99) >= send_idle_pct) begin
               op_type op;
               op = pending_ops.pop_front();
               req_tuser <= op.cmd;
               req_tdata <= {op.sf, op.bi, op.br, op.ai, op.ar};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver ready
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         answer_type e;
         logic [31:0] re, im;
         logic fl;
         logic [1:0] st;
         re = rsp_tdata[31:0];
         im = rsp_tdata[63:32];
         fl = rsp_tdata[64];
         st = rsp_tdata[66:65];
         if (expected_answers.size() == 0) begin
            $error("unexpected transfer re=%h im=%h", re, im);
            error_count++;
         end else begin
            e = expected_answers.pop_front();
            if (re !== e.re) begin
               $error("res_re expected %h actual %h", e.re, re); error_count++;
            end
            if (im !== e.im) begin
               $error("res_im expected %h actual %h", e.im, im); error_count++;
            end
            if (fl !== e.flag) begin
               $error("flag expected %b actual %b", e.flag, fl); error_count++;
            end
            if (st !== e.status) begin
               $error("status expected %0d actual %0d", e.status, st); error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("FAIL complex_arithmetic_unit");
         $finish;
      end
   end

   initial begin
      logic [31:0] mx, mn;
      mx = 32'h7fffffff;
      mn = 32'h80000000;
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      add_op(CMD_ADD, mx, mn, mx, mn, 0);
      add_op(CMD_ADD, 32'h10000, 32'hffff0000, 32'h8000, 32'h1, 0);
      add_op(CMD_SUB, mn, mx, 1, 32'hffffffff, 0);
      add_op(CMD_MUL, mx, mx, mx, mn, 0);
      add_op(CMD_MUL, mn, mn, mn, mn, 0);
      add_op(CMD_MUL, 32'hffffffff, 1, 3, 5, 0);
      add_op(CMD_SCALE, mx, mn, 0, 0, mn);
      add_op(CMD_SCALE, 32'hffffffff, 3, 0, 0, 32'h8000);
      add_op(CMD_DIV, 32'h10000, 0, 0, 0, 0);
      add_op(CMD_DIV, mx, mn, 1, 0, 0);
      add_op(CMD_DIV, mn, mn, mn, mn, 0);
      add_op(CMD_DIV, 32'hfffe0000, 32'h30000, 32'h20000, 32'hffff0000, 0);
      add_op(CMD_NEG, mn, mx, 0, 0, 0);
      add_op(CMD_MAG, mn, mn, 0, 0, 0);
      add_op(CMD_MAG, 32'h30000, 32'h40000, 0, 0, 0);
      add_op(CMD_EQ, 5, 6, 5, 6, 0);
      add_op(CMD_EQ, 5, 6, 5, 7, 0);
      add_op(CMD_NE, mn, mx, mn, mx, 0);
      add_op(CMD_NE, 1, 2, 3, 4, 0);
      add_op(CMD_LESS, 1, 1, 2, 0, 0);
      add_op(CMD_LESS, mn, 0, mx, 0, 0);
      add_op(4'd12, mx, mx, mx, mx, mx);
      add_op(4'd15, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      for (int i = 0; i < 380; i++) pending_ops.push_back(rand_op());
      drain();

      wait_drain = 1'b1;
      for (int i = 0; i < 80; i++) pending_ops.push_back(rand_op());
      wait_drain = 1'b0;
      @(negedge clock) hold_off = 300;
      drain();

      send_idle_pct = 65;
      recv_idle_pct = 17;
      for (int i = 0; i < 330; i++) pending_ops.push_back(rand_op());
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < 340; i++) pending_ops.push_back(rand_op());
      drain();

      repeat (60) @(posedge clock);
      if (error_count == 0)
         $display("PASS complex_arithmetic_unit");
      else
         $display("FAIL complex_arithmetic_unit");
      $finish;
   end
endmodule

`default_nettype wire
